// ===== rtl/core/atp_pkg.sv =====
package atp_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int GAIN_FRAC     = 12;
    localparam int CHAN_W        = 24;
    localparam int GAIN_W        = 15;
    localparam int PIX_W         = 8;
    localparam int GAMMA_ENTRIES = 1024;
    localparam int ADDR_W        = $clog2(GAMMA_ENTRIES);
    localparam int PROD_W        = CHAN_W + GAIN_W;
    localparam int SQ_W          = 2 * CHAN_W;
    localparam int ND_W          = SQ_W + 9;
    localparam int T_W           = FRAC_BITS + 1;
    localparam int DIV_STEPS     = FRAC_BITS;
    localparam int PIPE_DEPTH    = DIV_STEPS + 7;
    localparam int CFG_AW        = 3;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd4096;
    localparam logic [0:0] REG_EXPOSURE_GAIN = 1'b0;

    typedef logic [PIX_W-1:0] gamma_rom_t [GAMMA_ENTRIES];

    function automatic logic [159:0] big_pow(int b, int e);
        logic [159:0] acc;
        acc = 160'd1;
        for (int n = 0; n < e; n++)
        begin
            acc = acc * 160'(b);
        end
        return acc;
    endfunction

    function automatic bit gamma_fits(int v, int i);
        logic [159:0] lhs;
        logic [159:0] rhs;
        lhs = big_pow(v, 11) * big_pow(GAMMA_ENTRIES - 1, 5);
        rhs = big_pow(255, 11) * big_pow(i, 5);
        return lhs <= rhs;
    endfunction

    function automatic gamma_rom_t build_gamma();
        gamma_rom_t rom;
        int v;
        v = 0;
        for (int i = 0; i < GAMMA_ENTRIES; i++)
        begin
            while (v < 255 && gamma_fits(v + 1, i))
            begin
                v = v + 1;
            end
            rom[i] = PIX_W'(v);
        end
        return rom;
    endfunction

    localparam gamma_rom_t GAMMA_ROM = build_gamma();

endpackage

// ===== rtl/core/atp_channel.sv =====
module atp_channel
    import atp_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [CHAN_W-1:0] chan,
    input  logic [GAIN_W-1:0] gain,
    output logic [PIX_W-1:0]  pix
);

    logic [PROD_W-1:0] prod_reg;
    logic [CHAN_W-1:0] s_reg;
    logic [CHAN_W-1:0] s2_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [ND_W-1:0]   num_reg;
    logic [ND_W-1:0]   den_reg;
    logic [ND_W-1:0]   rem_reg [DIV_STEPS];
    logic [ND_W-1:0]   dv_reg  [DIV_STEPS];
    logic [FRAC_BITS-1:0] q_reg [DIV_STEPS+1];
    logic              ge_reg  [DIV_STEPS+1];
    logic [ADDR_W-1:0] addr_reg;
    logic [PIX_W-1:0]  pix_reg;

    logic [CHAN_W-1:0] s_next;
    logic [ND_W-1:0]   num_next;
    logic [ND_W-1:0]   den_next;
    logic [ND_W-1:0]   sh   [DIV_STEPS];
    logic              take [DIV_STEPS];
    logic [T_W-1:0]    t_fin;
    logic [T_W+ADDR_W-1:0] scaled;
    logic [ADDR_W-1:0] addr_next;

    // exposure saturation
    always_comb
    begin
        if (|prod_reg[PROD_W-1:GAIN_FRAC+CHAN_W])
            s_next = {CHAN_W{1'b1}};
        else
            s_next = prod_reg[GAIN_FRAC+CHAN_W-1:GAIN_FRAC];
    end

    assign num_next = ND_W'(sq_reg) * ND_W'(251)
                    + (ND_W'(s2_reg) * ND_W'(3) << FRAC_BITS);
    assign den_next = ND_W'(sq_reg) * ND_W'(243)
                    + (ND_W'(s2_reg) * ND_W'(59) << FRAC_BITS)
                    + (ND_W'(14) << (2 * FRAC_BITS));

    // restoring division, one quotient bit per stage
    always_comb
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            sh[k]   = {rem_reg[k][ND_W-2:0], 1'b0};
            take[k] = sh[k] >= dv_reg[k];
        end
    end

    assign t_fin  = ge_reg[DIV_STEPS] ? T_W'(1) << FRAC_BITS
                                      : {1'b0, q_reg[DIV_STEPS]};
    assign scaled = (T_W+ADDR_W)'(t_fin) * (T_W+ADDR_W)'(GAMMA_ENTRIES - 1)
                  + ((T_W+ADDR_W)'(1) << (FRAC_BITS - 1));
    assign addr_next = scaled[FRAC_BITS+ADDR_W-1:FRAC_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= PROD_W'(chan) * PROD_W'(gain);
            s_reg      <= s_next;
            sq_reg     <= SQ_W'(s_reg) * SQ_W'(s_reg);
            s2_reg     <= s_reg;
            num_reg    <= num_next;
            den_reg    <= den_next;
            rem_reg[0] <= num_reg;
            dv_reg[0]  <= den_reg;
            q_reg[0]   <= '0;
            ge_reg[0]  <= num_reg >= den_reg;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                q_reg[k+1]  <= {q_reg[k][FRAC_BITS-2:0], take[k]};
                ge_reg[k+1] <= ge_reg[k];
            end
            for (int k = 0; k < DIV_STEPS - 1; k++)
            begin
                rem_reg[k+1] <= take[k] ? sh[k] - dv_reg[k] : sh[k];
                dv_reg[k+1]  <= dv_reg[k];
            end
            addr_reg <= addr_next;
            pix_reg  <= GAMMA_ROM[addr_reg];
        end
    end

    assign pix = pix_reg;

endmodule

// ===== rtl/core/aces_tonemap_pixel.sv =====
// throughput: one item per cycle while the output is not stalled, set by the fully pipelined datapath
// (16-stage divider, one quotient bit per stage)
// a stalled output holds the whole pipeline
// reset clears the valid bits and sets exposure_gain to 4096
module aces_tonemap_pixel
    import atp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CHAN_W-1:0] red_in,
    input  logic [CHAN_W-1:0] green_in,
    input  logic [CHAN_W-1:0] blue_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PIX_W-1:0]  red_out,
    output logic [PIX_W-1:0]  green_out,
    output logic [PIX_W-1:0]  blue_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [GAIN_W-1:0]     gain_reg;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    logic                  en;
    logic                  wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_EXPOSURE_GAIN: prdata = {{(32-GAIN_W){1'b0}}, gain_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= GAIN_RESET;
        else if (wr && paddr[2] == REG_EXPOSURE_GAIN)
            gain_reg <= pwdata[GAIN_W-1:0];
    end

    assign en        = !(vld_reg[PIPE_DEPTH-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[PIPE_DEPTH-1];
    assign vld_next  = {vld_reg[PIPE_DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    atp_channel u_red
    (
        .clk  (clk),
        .en   (en),
        .chan (red_in),
        .gain (gain_reg),
        .pix  (red_out)
    );

    atp_channel u_green
    (
        .clk  (clk),
        .en   (en),
        .chan (green_in),
        .gain (gain_reg),
        .pix  (green_out)
    );

    atp_channel u_blue
    (
        .clk  (clk),
        .en   (en),
        .chan (blue_in),
        .gain (gain_reg),
        .pix  (blue_out)
    );

endmodule

// ===== rtl/core/atp_checker.sv =====
module atp_checker
    import atp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [PIX_W-1:0]  red_out,
    input logic [PIX_W-1:0]  green_out,
    input logic [PIX_W-1:0]  blue_out,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [CFG_AW-1:0] paddr,
    input logic [31:0]       pwdata,
    input logic [31:0]       prdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            $stable(red_out) && $stable(green_out) && $stable(blue_out))
        else $error("result changed under stall");

    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

    a_gain_rd: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[2] == REG_EXPOSURE_GAIN |=>
            paddr[2] != REG_EXPOSURE_GAIN
            || prdata == {{(32-GAIN_W){1'b0}}, $past(pwdata[GAIN_W-1:0])})
        else $error("gain readback mismatch");

endmodule

bind aces_tonemap_pixel atp_checker u_atp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

// ===== verif/aces_tonemap_pixel_tb.sv =====
module aces_tonemap_pixel_tb;
    import atp_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } hdr_pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } ldr_pixel_t;

    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 120;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic out_valid;
    logic out_stall;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    aces_tonemap_pixel i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    hdr_pixel_t pending_pixels[$];
    ldr_pixel_t expected_pixels[$];
    logic [GAIN_W-1:0] model_gain;
    logic [PIX_W-1:0] srgb_rom [GAMMA_ENTRIES];
    int errors;
    int accepted_in;
    int accepted_out;
    int idle_cycles;
    int send_gap;
    int recv_gap;
    int hold_off;
    bit hold_req;
    bit hold_seen;
    bit send_pause;

    // independent gamma table: largest v with (v/255)^11 <= (i/M)^5
    function automatic logic [255:0] ipow(int b, int e);
        logic [255:0] acc;
        acc = 256'd1;
        for (int n = 0; n < e; n++)
        begin
            acc = acc * 256'(b);
        end
        return acc;
    endfunction

    task automatic fill_srgb_rom();
        int v;
        logic [255:0] m5;
        m5 = ipow(GAMMA_ENTRIES - 1, 5);
        v = 0;
        for (int i = 0; i < GAMMA_ENTRIES; i++)
        begin
            while (v < 255 && ipow(v + 1, 11) * m5 <= ipow(255, 11) * ipow(i, 5))
            begin
                v++;
            end
            srgb_rom[i] = PIX_W'(v);
        end
    endtask

    function automatic logic [PIX_W-1:0] tonemap_channel(logic [CHAN_W-1:0] x);
        logic [127:0] one, s, num, den, t, addr;
        one = 128'd1 << FRAC_BITS;
        s = (128'(x) * 128'(model_gain)) >> GAIN_FRAC;
        if (s > 128'hFFFFFF)
        begin
            s = 128'hFFFFFF;
        end
        num = s * (251 * s + 3 * one);
        den = s * (243 * s + 59 * one) + 14 * one * one;
        if (num >= den)
        begin
            t = one;
        end
        else
        begin
            t = (num << FRAC_BITS) / den;
        end
        addr = (t * (GAMMA_ENTRIES - 1) + (one >> 1)) >> FRAC_BITS;
        if (addr > GAMMA_ENTRIES - 1)
        begin
            addr = GAMMA_ENTRIES - 1;
        end
        return srgb_rom[addr];
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
        begin
            return 0;
        end
        if (p < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return CHAN_W'($urandom_range(0, 255));
            1: return CHAN_W'($urandom_range(0, 32'h1FFFF));
            2: return CHAN_W'($urandom_range(0, 32'h7FFFF));
            3: return CHAN_W'($urandom_range(32'hFF0000, 32'hFFFFFF));
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    always #5 clk = ~clk;

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
            red_in <= '0;
            green_in <= '0;
            blue_in <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                accepted_in++;
                void'(pending_pixels.pop_front());
            end
            if (in_valid && in_stall)
            begin
                // hold payload
            end
            else if (send_gap > 0 || send_pause)
            begin
                in_valid <= 1'b0;
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                end
            end
            else
            begin
                if (in_valid && !in_stall)
                begin
                    send_gap <= pick_gap();
                end
                if (pending_pixels.size() > 0 && !(in_valid && !in_stall && send_gap == 0
                    && pending_pixels.size() == 0))
                begin
                    in_valid <= !(in_valid && !in_stall) || pending_pixels.size() > 0;
                    red_in <= pending_pixels[0].r;
                    green_in <= pending_pixels[0].g;
                    blue_in <= pending_pixels[0].b;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_off <= HOLD_CYCLES;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        ldr_pixel_t exp_px;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                exp_px.r = tonemap_channel(red_in);
                exp_px.g = tonemap_channel(green_in);
                exp_px.b = tonemap_channel(blue_in);
                expected_pixels = {expected_pixels, exp_px};
            end
            if (out_valid && !out_stall)
            begin
                accepted_out++;
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected item red=%0d green=%0d blue=%0d",
                        red_out, green_out, blue_out);
                    errors++;
                end
                else
                begin
                    exp_px = expected_pixels.pop_front();
                    if (red_out !== exp_px.r)
                    begin
                        $error("red_out expected %0d got %0d", exp_px.r, red_out);
                        errors++;
                    end
                    if (green_out !== exp_px.g)
                    begin
                        $error("green_out expected %0d got %0d", exp_px.g, green_out);
                        errors++;
                    end
                    if (blue_out !== exp_px.b)
                    begin
                        $error("blue_out expected %0d got %0d", exp_px.b, blue_out);
                        errors++;
                    end
                end
            end
            if (hold_off > 0)
            begin
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (out_valid && !out_stall)
                begin
                    recv_gap <= pick_gap();
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no progress in %0d cycles", IDLE_LIMIT);
                $display("aces_tonemap_pixel verification failed");
                $finish;
            end
        end
        else
        begin
            idle_cycles <= 0;
        end
    end

    task automatic apb_write(logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_AW'(REG_EXPOSURE_GAIN) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model_gain = GAIN_W'(value);
    endtask

    task automatic drain();
        while (pending_pixels.size() > 0 || in_valid || expected_pixels.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 5) @(posedge clk);
    endtask

    task automatic push_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
        logic [CHAN_W-1:0] b);
        hdr_pixel_t p;
        p.r = r;
        p.g = g;
        p.b = b;
        pending_pixels = {pending_pixels, p};
    endtask

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++)
        begin
            push_pixel(rand_chan(), rand_chan(), rand_chan());
        end
    endtask

    initial
    begin
        logic [31:0] gains [9];
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        accepted_in = 0;
        accepted_out = 0;
        hold_req = 1'b0;
        send_pause = 1'b0;
        model_gain = GAIN_RESET;
        fill_srgb_rom();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset gain, directed corners
        push_pixel(24'h0, 24'h0, 24'h0);
        push_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        push_pixel(24'h010000, 24'h008000, 24'h000001);
        push_pixel(24'hAAAAAA, 24'h555555, 24'hFFFFFF);
        push_pixel(24'h555555, 24'hAAAAAA, 24'h000000);
        push_pixel(24'h000100, 24'h002000, 24'h040000);
        for (int k = 0; k < 24; k++)
        begin
            push_pixel(CHAN_W'(1) << k, ~(CHAN_W'(1) << k), CHAN_W'(k) << 14);
        end
        drain();

        gains = '{32'd0, 32'd819, 32'd20480, 32'h7FFF, 32'd1, 32'd4096,
            32'hFFFF8000, 32'd2048, 32'd12000};
        for (int gi = 0; gi < 9; gi++)
        begin
            apb_write(gi == 8 ? 32'($urandom_range(819, 20480)) : gains[gi]);
            push_pixel(24'hFFFFFF, 24'h0, 24'h010000);
            random_phase(gi == 0 ? 30 : 180);
            if (gi == 3)
            begin
                // long receiver hold-off while the sender keeps going
                hold_req = !hold_req;
            end
            if (gi == 5)
            begin
                while (pending_pixels.size() >= 90)
                begin
                    @(posedge clk);
                end
                send_pause = 1'b1;
                while (expected_pixels.size() > 0 || in_valid)
                begin
                    @(posedge clk);
                end
                send_pause = 1'b0;
            end
            drain();
        end
        apb_write(32'($urandom_range(0, 32'h7FFF)));
        random_phase(390);
        drain();

        $display("covered %0d pixels in, %0d out, over eleven exposure settings",
            accepted_in, accepted_out);
        $display("including zero, extreme and out-of-range gains with stall pressure");
        if (errors == 0)
        begin
            $display("aces_tonemap_pixel verification clean");
        end
        else
        begin
            $display("aces_tonemap_pixel verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/atp_pkg.sv
rtl/core/atp_channel.sv
rtl/core/aces_tonemap_pixel.sv
rtl/core/atp_checker.sv
verif/aces_tonemap_pixel_tb.sv
